/* design/efws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efws_pkg
// Shared constants and types for the earliest-free-worker scheduler.
// ----------------------------------------------------------------------------
package efws_pkg;

    localparam int MAX_WORKERS   = 16;
    localparam int RESET_WORKERS = 16;
    localparam int RESET_COUNT   = (RESET_WORKERS > MAX_WORKERS) ? MAX_WORKERS : RESET_WORKERS;

    localparam int ADDR_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W   = $clog2(MAX_WORKERS + 1);
    localparam int CHILD_W = ADDR_W + 2;

    localparam int DUR_W  = 32;
    localparam int TIME_W = 64;
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_PAD_W   = OUT_TDATA_W - TIME_W - IDX_W;

    typedef struct packed {
        logic [TIME_W-1:0] free_time;
        logic [ADDR_W-1:0] worker;
    } heap_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SELECT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic fetch;
        logic select;
    } dp_cmd_t;

    typedef struct packed {
        logic leaf;
        logic keep;
    } dp_status_t;

endpackage

/* design/efws_heap_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efws_heap_mem
// Heap storage: one write port, two registered read ports, per-entry valid
// bits so that an unwritten slot reads as its reset pair (worker = slot, 0).
// ----------------------------------------------------------------------------
module efws_heap_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clr,
    input  logic                          rd_en,
    input  logic [efws_pkg::ADDR_W-1:0]   rd_addr_a,
    input  logic [efws_pkg::ADDR_W-1:0]   rd_addr_b,
    output efws_pkg::heap_entry_t         rd_data_a,
    output efws_pkg::heap_entry_t         rd_data_b,
    input  logic                          wr_en,
    input  logic [efws_pkg::ADDR_W-1:0]   wr_addr,
    input  efws_pkg::heap_entry_t         wr_data
);

    efws_pkg::heap_entry_t                  mem_reg [efws_pkg::MAX_WORKERS];
    logic [efws_pkg::MAX_WORKERS-1:0]       valid_reg;
    efws_pkg::heap_entry_t                  rd_a_reg;
    efws_pkg::heap_entry_t                  rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (valid_reg[rd_addr_a])
            begin
                rd_a_reg <= mem_reg[rd_addr_a];
            end
            else
            begin
                rd_a_reg.free_time <= '0;
                rd_a_reg.worker    <= rd_addr_a;
            end
            if (valid_reg[rd_addr_b])
            begin
                rd_b_reg <= mem_reg[rd_addr_b];
            end
            else
            begin
                rd_b_reg.free_time <= '0;
                rd_b_reg.worker    <= rd_addr_b;
            end
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

/* design/efws_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efws_datapath
// Worker count, root copy, sift-down position and element, child compare,
// heap memory and the result register.
// ----------------------------------------------------------------------------
module efws_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [efws_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic [efws_pkg::DUR_W-1:0]        job_duration,
    input  efws_pkg::dp_cmd_t                 cmd,
    output efws_pkg::dp_status_t              status,
    output logic [efws_pkg::IDX_W-1:0]        worker_index,
    output logic [efws_pkg::TIME_W-1:0]       start_time
);

    logic [efws_pkg::CNT_W-1:0]     n_reg;
    logic [efws_pkg::CNT_W-1:0]     n_next;
    efws_pkg::heap_entry_t          cache_reg;
    efws_pkg::heap_entry_t          cur_reg;
    efws_pkg::heap_entry_t          out_reg;
    logic [efws_pkg::ADDR_W-1:0]    pos_reg;

    logic [efws_pkg::CHILD_W-1:0]   l_idx;
    logic [efws_pkg::CHILD_W-1:0]   r_idx;
    logic [efws_pkg::CHILD_W-1:0]   n_ext;
    logic                           l_ok;
    logic                           r_ok;
    efws_pkg::heap_entry_t          rd_a;
    efws_pkg::heap_entry_t          rd_b;
    efws_pkg::heap_entry_t          cand;
    efws_pkg::heap_entry_t          child;
    logic [efws_pkg::ADDR_W-1:0]    child_pos;
    logic                           l_wins;
    logic                           r_wins;
    logic                           keep;
    logic [efws_pkg::TIME_W:0]      sum;
    logic [efws_pkg::TIME_W-1:0]    sat_time;
    logic                           wr_en;
    logic [efws_pkg::ADDR_W-1:0]    wr_addr;
    efws_pkg::heap_entry_t          wr_data;
    logic                           rd_en;

    function automatic logic entry_less(efws_pkg::heap_entry_t a, efws_pkg::heap_entry_t b);
        logic res;
        if (a.free_time != b.free_time)
        begin
            res = a.free_time < b.free_time;
        end
        else
        begin
            res = a.worker < b.worker;
        end
        return res;
    endfunction

    // clamp requested count into 1..MAX_WORKERS
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            n_next = efws_pkg::CNT_W'(1);
        end
        else if (int'(cfg_wdata) > efws_pkg::MAX_WORKERS)
        begin
            n_next = efws_pkg::CNT_W'(efws_pkg::MAX_WORKERS);
        end
        else
        begin
            n_next = efws_pkg::CNT_W'(cfg_wdata);
        end
    end

    assign l_idx = efws_pkg::CHILD_W'({pos_reg, 1'b1});
    assign r_idx = l_idx + efws_pkg::CHILD_W'(1);
    assign n_ext = efws_pkg::CHILD_W'(n_reg);
    assign l_ok  = l_idx < n_ext;
    assign r_ok  = r_idx < n_ext;

    // left child first, then right against the winner
    always_comb
    begin
        l_wins = entry_less(rd_a, cur_reg);
        cand   = l_wins ? rd_a : cur_reg;
        r_wins = r_ok && entry_less(rd_b, cand);
        keep   = !l_wins && !r_wins;
        if (r_wins)
        begin
            child     = rd_b;
            child_pos = efws_pkg::ADDR_W'(r_idx);
        end
        else
        begin
            child     = rd_a;
            child_pos = efws_pkg::ADDR_W'(l_idx);
        end
    end

    assign status.leaf = !l_ok;
    assign status.keep = keep;

    // saturating free-time update
    assign sum      = {1'b0, cache_reg.free_time}
                    + {{(efws_pkg::TIME_W + 1 - efws_pkg::DUR_W){1'b0}}, job_duration};
    assign sat_time = sum[efws_pkg::TIME_W] ? {efws_pkg::TIME_W{1'b1}}
                                            : sum[efws_pkg::TIME_W-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = cur_reg;
        if (cmd.fetch && !l_ok)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.select)
        begin
            wr_en   = 1'b1;
            wr_data = keep ? cur_reg : child;
        end
    end

    assign rd_en = cmd.fetch && l_ok;

    efws_heap_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (cfg_we),
        .rd_en     (rd_en),
        .rd_addr_a (efws_pkg::ADDR_W'(l_idx)),
        .rd_addr_b (efws_pkg::ADDR_W'(r_idx)),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= efws_pkg::CNT_W'(efws_pkg::RESET_COUNT);
            cache_reg <= '0;
        end
        else if (cfg_we)
        begin
            n_reg     <= n_next;
            cache_reg <= '0;
        end
        else if (wr_en && wr_addr == '0)
        begin
            cache_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.load)
        begin
            pos_reg <= '0;
        end
        else if (cmd.select && !keep)
        begin
            pos_reg <= child_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg.free_time <= sat_time;
            cur_reg.worker    <= cache_reg.worker;
            out_reg           <= cache_reg;
        end
    end

    assign worker_index = efws_pkg::IDX_W'(out_reg.worker);
    assign start_time   = out_reg.free_time;

`ifndef ASSERT_OFF
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |-> efws_pkg::CHILD_W'(pos_reg) < n_ext)
        else $error("sift position beyond active worker count");

    a_pos_descends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.select && !keep && !cmd.load) |=> pos_reg > $past(pos_reg))
        else $error("sift step did not move down the heap");

    a_root_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_addr == '0 && !cfg_we) |=> cache_reg == $past(wr_data))
        else $error("root copy out of step with heap slot zero");
`endif

endmodule

/* design/efws_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efws_ctrl
// Sequencer for request acceptance, the sift-down walk and the result valid.
// ----------------------------------------------------------------------------
module efws_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output efws_pkg::dp_cmd_t     cmd,
    input  efws_pkg::dp_status_t  status
);

    efws_pkg::ctrl_state_t  state_reg;
    efws_pkg::ctrl_state_t  state_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= efws_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            efws_pkg::ST_IDLE:
            begin
                // result slot frees up in the same cycle it is taken
                s_tready = !out_valid_reg || m_tready;
                accept   = s_tready && s_tvalid;
                cmd.load = accept;
                if (accept)
                begin
                    state_next = efws_pkg::ST_FETCH;
                end
            end
            efws_pkg::ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                state_next = status.leaf ? efws_pkg::ST_IDLE : efws_pkg::ST_SELECT;
            end
            efws_pkg::ST_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = status.keep ? efws_pkg::ST_IDLE : efws_pkg::ST_FETCH;
            end
            default:
            begin
                state_next = efws_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_starts_sift: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == efws_pkg::ST_FETCH) && out_valid_reg)
        else $error("accepted request did not start a sift with a valid result");

    a_keep_ends_sift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == efws_pkg::ST_SELECT && status.keep) |=> state_reg == efws_pkg::ST_IDLE)
        else $error("sift did not stop once the element settled");
`endif

endmodule

/* design/earliest_free_worker_scheduler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_core
// Hands each job to the worker that becomes free earliest (lowest index on a
// tie) using a binary min-heap of (free time, worker) pairs.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one job request per beat, tdata = job duration (32 bits).
//   m_axis returns one result per request: tdata[3:0] worker index,
//   tdata[67:4] start time, upper bits zero.
//   cfg_we/cfg_wdata set the active worker count (0 taken as 1, values above
//   16 taken as 16) and restart every worker at time zero; write only while
//   the block is idle.
// request flow:
//   the result is registered when the request is accepted. the heap update then
//   walks down the tree, a registered child read and then a compare and write
//   back per level, until the element settles or a leaf slot is written back
//   directly.
// reset: all 16 workers active and free at time zero; no clearing pass.
// stall: a held result stays put; the next request is taken once the heap
//   update is done and the result register is empty or being drained.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [efws_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // job_duration
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [efws_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // worker_index, start_time
    input  logic                                  cfg_we,
    input  logic [efws_pkg::CFG_W-1:0]            cfg_wdata      // num_workers
);

    efws_pkg::dp_cmd_t              cmd;
    efws_pkg::dp_status_t           status;
    logic [efws_pkg::IDX_W-1:0]     worker_index;
    logic [efws_pkg::TIME_W-1:0]    start_time;

    efws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    efws_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .job_duration (s_axis_tdata[efws_pkg::DUR_W-1:0]),
        .cmd          (cmd),
        .status       (status),
        .worker_index (worker_index),
        .start_time   (start_time)
    );

    assign m_axis_tdata = {{efws_pkg::OUT_PAD_W{1'b0}}, start_time, worker_index};

endmodule

/* dv/earliest_free_worker_scheduler_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_core_tb
// Streams job durations into the scheduler and checks every assignment
// (worker, start time) against a min-heap predictor kept in the bench. Runs
// a directed opening, then random phases at several worker counts, with
// random idle cycles on both streams and one phase with no idling.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler_core_tb;

    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [efws_pkg::IDX_W-1:0]  worker;
        logic [efws_pkg::TIME_W-1:0] start;
    } assignment_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [efws_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [efws_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                               cfg_we = 1'b0;
    logic [efws_pkg::CFG_W-1:0]         cfg_wdata = '0;

    // bench copy of the heap
    logic [efws_pkg::ADDR_W-1:0]        slot_worker [efws_pkg::MAX_WORKERS];
    logic [efws_pkg::TIME_W-1:0]        slot_time [efws_pkg::MAX_WORKERS];
    int                                 active_workers;

    logic [efws_pkg::DUR_W-1:0]         pending_jobs [$];
    assignment_t                        assignment_queue [$];
    bit                                 steady = 1'b0;
    int                                 error_count = 0;

    earliest_free_worker_scheduler_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic void restart_workers(input logic [efws_pkg::CFG_W-1:0] req);
        int count;
        count = int'(req);
        if (count < 1)
            count = 1;
        if (count > efws_pkg::MAX_WORKERS)
            count = efws_pkg::MAX_WORKERS;
        active_workers = count;
        for (int i = 0; i < efws_pkg::MAX_WORKERS; i++)
        begin
            slot_worker[i] = efws_pkg::ADDR_W'(i);
            slot_time[i]   = '0;
        end
    endfunction

    function automatic bit frees_earlier(input int a, input int b);
        if (slot_time[a] != slot_time[b])
            return slot_time[a] < slot_time[b];
        return slot_worker[a] < slot_worker[b];
    endfunction

    function automatic assignment_t assign_job(input logic [efws_pkg::DUR_W-1:0] dur);
        assignment_t                    result;
        logic [efws_pkg::TIME_W:0]      sum;
        logic [efws_pkg::ADDR_W-1:0]    tw;
        logic [efws_pkg::TIME_W-1:0]    tt;
        int                             pos;
        int                             best;
        bit                             done;
        result.worker = efws_pkg::IDX_W'(slot_worker[0]);
        result.start  = slot_time[0];
        sum = {1'b0, slot_time[0]} + (efws_pkg::TIME_W + 1)'(dur);
        // free time saturates instead of wrapping
        slot_time[0] = sum[efws_pkg::TIME_W] ? {efws_pkg::TIME_W{1'b1}}
                                             : sum[efws_pkg::TIME_W-1:0];
        pos  = 0;
        done = 1'b0;
        while (!done)
        begin
            best = pos;
            if (2 * pos + 1 < active_workers && frees_earlier(2 * pos + 1, best))
                best = 2 * pos + 1;
            if (2 * pos + 2 < active_workers && frees_earlier(2 * pos + 2, best))
                best = 2 * pos + 2;
            if (best == pos)
                done = 1'b1;
            else
            begin
                tw = slot_worker[pos];
                slot_worker[pos] = slot_worker[best];
                slot_worker[best] = tw;
                tt = slot_time[pos];
                slot_time[pos] = slot_time[best];
                slot_time[best] = tt;
                pos = best;
            end
        end
        return result;
    endfunction

    function automatic logic [efws_pkg::DUR_W-1:0] random_duration();
        case ($urandom_range(0, 3))
            0: return efws_pkg::DUR_W'($urandom_range(0, 3));      // many ties
            1: return efws_pkg::DUR_W'($urandom_range(0, 255));
            2: return efws_pkg::DUR_W'($urandom);
            default: return $urandom_range(0, 1) ? {efws_pkg::DUR_W{1'b1}} : '0;
        endcase
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                assignment_queue = {assignment_queue, assign_job(s_axis_tdata)};
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_jobs.size() > 0 && (steady || $urandom_range(0, 99) >= 18))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_jobs.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        assignment_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 18);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (assignment_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, got worker %0d start %0d", $time,
                             m_axis_tdata[efws_pkg::IDX_W-1:0],
                             m_axis_tdata[efws_pkg::IDX_W +: efws_pkg::TIME_W]);
                    error_count++;
                end
                else
                begin
                    want = assignment_queue.pop_front();
                    if (m_axis_tdata[efws_pkg::IDX_W-1:0] !== want.worker)
                    begin
                        $display("%0t: worker mismatch, expected %0d, got %0d", $time,
                                 want.worker, m_axis_tdata[efws_pkg::IDX_W-1:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[efws_pkg::IDX_W +: efws_pkg::TIME_W] !== want.start)
                    begin
                        $display("%0t: start time mismatch, expected %0d, got %0d", $time,
                                 want.start, m_axis_tdata[efws_pkg::IDX_W +: efws_pkg::TIME_W]);
                        error_count++;
                    end
                end
            end
        end
    end

    // wait until every request is taken and answered, then let the heap update finish
    task automatic settle();
        while (pending_jobs.size() != 0 || s_axis_tvalid || assignment_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_workers(input logic [efws_pkg::CFG_W-1:0] req);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= req;
        restart_workers(req);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic [efws_pkg::CFG_W-1:0] req;
        restart_workers(efws_pkg::CFG_W'(efws_pkg::RESET_COUNT));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // all sixteen workers from reset: extremes and ties at time zero
        pending_jobs = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd2,
                         32'h8000_0000, 32'hFFFF_FFFF, 32'd3, 32'h7FFF_FFFF, 32'd0, 32'd1};
        settle();

        // zero workers requested is taken as one; start times climb past 32 bits
        set_workers(5'd0);
        repeat (6) pending_jobs = {pending_jobs, 32'hFFFF_FFFF};
        settle();

        // too many workers requested saturates to the maximum
        set_workers(5'd31);
        pending_jobs = '{32'd5, 32'd5, 32'd5, 32'd0};
        settle();

        for (int phase = 0; phase < 11; phase++)
        begin
            case (phase)
                0: req = 5'd16;
                1: req = 5'd1;
                2: req = 5'd2;
                3: req = 5'd3;
                4: req = 5'd17;
                5: req = 5'd5;
                default: req = efws_pkg::CFG_W'($urandom_range(0, 31));
            endcase
            set_workers(req);
            steady = (phase == 3);
            for (int i = 0; i < 86; i++)
                pending_jobs = {pending_jobs, random_duration()};
            settle();
        end

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
